// File: rtl/tsev_pkg.sv
// Shared types and constants for the series evaluator.
package tsev_pkg;

  typedef enum logic [1:0] {
    OP_PI  = 2'd0,
    OP_EXP = 2'd1,
    OP_SIN = 2'd2,
    OP_COS = 2'd3
  } op_t;

  localparam int CFG_W   = 12;
  localparam logic [CFG_W-1:0] CFG_RESET = 12'd8;
  localparam int CFG_MAX = 4095;

  localparam int X_W   = 32;
  localparam int RES_W = 64;

  // term magnitudes stay below 2^63
  localparam int MAG_W = 63;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] MAG_ONE = 63'h1_0000_0000;

  // 63 x 32 bit product
  localparam int PROD_W = MAG_W + X_W;

  // divider: dividend width and quotient bits per cycle
  localparam int DIV_W     = 96;
  localparam int DIV_STEPS = 4;
  localparam logic [DIV_W-1:0] PI_DIVIDEND = 96'h4_0000_0000;

  localparam logic [RES_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

endpackage

// File: rtl/tsev_mul.sv
// Two-pass 63x32 unsigned multiplier built on one 32x32 multiplier.
module tsev_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsev_pkg::MAG_W-1:0]    a,
  input  logic [tsev_pkg::X_W-1:0]      b,
  output logic                          done,
  output logic [tsev_pkg::PROD_W-1:0]   prod
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_SUM
  } mphase_t;

  mphase_t                          phase_r, phase_nxt;
  logic [tsev_pkg::MAG_W-1:0]       a_r, a_nxt;
  logic [tsev_pkg::X_W-1:0]         b_r, b_nxt;
  logic [63:0]                      pp_lo_r, pp_lo_nxt;
  logic [63:0]                      pp_hi_r, pp_hi_nxt;
  logic [tsev_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic                             done_r, done_nxt;
  logic [31:0]                      mul_a;
  logic [63:0]                      mul_out;

  // the one shared multiplier: low half of a, then high half
  assign mul_a   = (phase_r == M_LO) ? a_r[31:0] : {1'b0, a_r[tsev_pkg::MAG_W-1:32]};
  assign mul_out = mul_a * b_r;

  always_comb begin
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    pp_lo_nxt = pp_lo_r;
    pp_hi_nxt = pp_hi_r;
    prod_nxt  = prod_r;
    done_nxt  = 1'b0;
    case (phase_r)
      M_IDLE: begin
        if (start) begin
          a_nxt     = a;
          b_nxt     = b;
          phase_nxt = M_LO;
        end
      end
      M_LO: begin
        pp_lo_nxt = mul_out;
        phase_nxt = M_HI;
      end
      M_HI: begin
        pp_hi_nxt = mul_out;
        phase_nxt = M_SUM;
      end
      M_SUM: begin
        prod_nxt  = tsev_pkg::PROD_W'({pp_hi_r, 32'd0}) + tsev_pkg::PROD_W'(pp_lo_r);
        done_nxt  = 1'b1;
        phase_nxt = M_IDLE;
      end
      default: phase_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    pp_lo_r <= pp_lo_nxt;
    pp_hi_r <= pp_hi_nxt;
    prod_r  <= prod_nxt;
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// File: rtl/tsev_div.sv
// Restoring divider, 96-bit dividend, DIV_STEPS quotient bits per cycle.
module tsev_div #(
  parameter int DEN_W = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tsev_pkg::DIV_W-1:0]  dividend,
  input  logic [DEN_W-1:0]            divisor,
  output logic                        done,
  output logic [tsev_pkg::DIV_W-1:0]  quotient
);

  localparam int CYCLES = tsev_pkg::DIV_W / tsev_pkg::DIV_STEPS;
  localparam int CW     = $clog2(CYCLES + 1);

  logic [tsev_pkg::DIV_W-1:0] work_r, work_nxt;
  logic [DEN_W-1:0]           rem_r, rem_nxt;
  logic [DEN_W-1:0]           den_r, den_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [tsev_pkg::DIV_W-1:0] w_step;
  logic [DEN_W-1:0]           r_step;

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_comb begin
    logic [DEN_W:0] cur;
    w_step = work_r;
    r_step = rem_r;
    for (int i = 0; i < tsev_pkg::DIV_STEPS; i++) begin
      cur    = {r_step, w_step[tsev_pkg::DIV_W-1]};
      w_step = {w_step[tsev_pkg::DIV_W-2:0], 1'b0};
      if (cur >= {1'b0, den_r}) begin
        cur       = cur - {1'b0, den_r};
        w_step[0] = 1'b1;
      end
      r_step = cur[DEN_W-1:0];
    end
  end

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      work_nxt = w_step;
      rem_nxt  = r_step;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CW'(CYCLES);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

// File: rtl/taylor_series_evaluator_top.sv
// Series evaluator top: sequencer, term and sum registers, config and stream ports.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------------
//  in       | in_tvalid/in_tready/tdata/tuser| x (Q3.28), opcode
//  out      | out_tvalid/out_tready/tdata/...| result (Q31.32), overflow flag
//  cfg      | cfg_wr_en/cfg_wr_data          | term_count
//
// One item at a time. All terms but the first series term use the shared divider:
// a pi term is step, divide, add; a series step is multiply, divide, add.
// exp takes n-1 steps, sin 2n-1, cos 2n-2, pi n; a zero term count skips to done.
// Synchronous active-low reset; term_count resets to 8.
// The next input transfer is taken while a finished result still waits on out.
module taylor_series_evaluator_top #(
  parameter int MAX_TERMS = 4095,
  parameter int FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config
  input  logic                          cfg_wr_en,
  input  logic [tsev_pkg::CFG_W-1:0]    cfg_wr_data,   // term_count
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tsev_pkg::X_W-1:0]      in_tdata,      // [31:0] x
  input  logic [1:0]                    in_tuser,      // [1:0] opcode
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tsev_pkg::RES_W-1:0]    out_tdata,     // [63:0] result
  output logic                          out_tuser      // [0] overflow
);

  localparam int NMAX = (MAX_TERMS < tsev_pkg::CFG_MAX) ? MAX_TERMS : tsev_pkg::CFG_MAX;
  localparam int NW   = $clog2(NMAX + 1);
  localparam int JW   = $clog2(2 * NMAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_DIV,
    S_ADD,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  tsev_pkg::op_t                  op_r, op_nxt;
  logic [tsev_pkg::X_W-1:0]       xmag_r, xmag_nxt;
  logic                           xneg_r, xneg_nxt;
  logic [JW-1:0]                  j_r, j_nxt;
  logic [JW-1:0]                  jlast_r, jlast_nxt;
  logic [tsev_pkg::MAG_W-1:0]     mag_r, mag_nxt;
  logic                           tneg_r, tneg_nxt;
  logic [tsev_pkg::RES_W-1:0]     acc_r, acc_nxt;
  logic                           flag_r, flag_nxt;
  logic [tsev_pkg::RES_W-1:0]     out_data_r, out_data_nxt;
  logic                           out_flag_r, out_flag_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [tsev_pkg::CFG_W-1:0]     term_count_r;

  logic                           in_xfer;
  logic                           load_out;
  logic [NW-1:0]                  n_val;
  logic [JW:0]                    n2;
  logic [JW-1:0]                  pi_den;
  logic                           mul_start, mul_done;
  logic [tsev_pkg::PROD_W-1:0]    mul_prod;
  logic                           div_start, div_done;
  logic [tsev_pkg::DIV_W-1:0]     div_dividend, div_quot;
  logic [JW-1:0]                  div_divisor;
  logic                           q_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= tsev_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      term_count_r <= cfg_wr_data;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign n_val  = (32'(term_count_r) > NMAX) ? NW'(NMAX) : NW'(term_count_r);
  assign n2     = (JW + 1)'(n_val) << 1;
  assign pi_den = JW'(((JW + 1)'(j_r) << 1) - 1'b1);

  assign mul_start    = (state_r == S_STEP) && (op_r != tsev_pkg::OP_PI) && (j_r != '0);
  assign div_start    = ((state_r == S_STEP) && (op_r == tsev_pkg::OP_PI)) ||
                        ((state_r == S_MUL) && mul_done);
  assign div_dividend = (op_r == tsev_pkg::OP_PI) ? tsev_pkg::PI_DIVIDEND :
                        (tsev_pkg::DIV_W'(mul_prod) >> FRAC_BITS);
  assign div_divisor  = (op_r == tsev_pkg::OP_PI) ? pi_den : j_r;
  assign q_sat        = |div_quot[tsev_pkg::DIV_W-1:tsev_pkg::MAG_W];

  tsev_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mag_r),
    .b     (xmag_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tsev_div #(
    .DEN_W (JW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    logic                       sel;
    logic                       neg;
    logic [1:0]                 jlo;
    logic [tsev_pkg::RES_W-1:0] v;
    logic [tsev_pkg::RES_W-1:0] s;
    logic                       ovf;

    state_nxt     = state_r;
    op_nxt        = op_r;
    xmag_nxt      = xmag_r;
    xneg_nxt      = xneg_r;
    j_nxt         = j_r;
    jlast_nxt     = jlast_r;
    mag_nxt       = mag_r;
    tneg_nxt      = tneg_r;
    acc_nxt       = acc_r;
    flag_nxt      = flag_r;
    out_data_nxt  = out_data_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_tready;

    jlo = 2'(j_r);
    sel = 1'b1;
    neg = tneg_r;
    case (op_r)
      tsev_pkg::OP_PI: begin
        sel = 1'b1;
        neg = !j_r[0];
      end
      tsev_pkg::OP_EXP: begin
        sel = 1'b1;
        neg = tneg_r;
      end
      tsev_pkg::OP_SIN: begin
        sel = j_r[0];
        neg = tneg_r ^ (jlo == 2'b11);
      end
      tsev_pkg::OP_COS: begin
        sel = !j_r[0];
        neg = tneg_r ^ (jlo == 2'b10);
      end
      default: begin
        sel = 1'b0;
        neg = 1'b0;
      end
    endcase
    v   = neg ? (tsev_pkg::RES_W'(0) - {1'b0, mag_r}) : {1'b0, mag_r};
    s   = acc_r + v;
    ovf = (acc_r[63] == v[63]) && (s[63] != acc_r[63]);

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt   = tsev_pkg::op_t'(in_tuser);
          xneg_nxt = in_tdata[tsev_pkg::X_W-1];
          xmag_nxt = in_tdata[tsev_pkg::X_W-1] ? (tsev_pkg::X_W'(0) - in_tdata) : in_tdata;
          acc_nxt  = '0;
          flag_nxt = 1'b0;
          mag_nxt  = tsev_pkg::MAG_ONE;
          tneg_nxt = 1'b0;
          case (tsev_pkg::op_t'(in_tuser))
            tsev_pkg::OP_PI: begin
              j_nxt     = JW'(1);
              jlast_nxt = JW'(n_val);
            end
            tsev_pkg::OP_EXP: begin
              j_nxt     = '0;
              jlast_nxt = JW'((JW + 1)'(n_val) - 1'b1);
            end
            tsev_pkg::OP_SIN: begin
              j_nxt     = '0;
              jlast_nxt = JW'(n2 - 1'b1);
            end
            tsev_pkg::OP_COS: begin
              j_nxt     = '0;
              jlast_nxt = JW'(n2 - 2'd2);
            end
            default: begin
              j_nxt     = '0;
              jlast_nxt = '0;
            end
          endcase
          state_nxt = (n_val == '0) ? S_DONE : S_STEP;
        end
      end
      S_STEP: begin
        // first series term is 1.0 and needs no divide
        if (op_r == tsev_pkg::OP_PI) begin
          state_nxt = S_DIV;
        end else if (j_r == '0) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_r == tsev_pkg::OP_PI) begin
            mag_nxt = div_quot[tsev_pkg::MAG_W-1:0];
          end else begin
            mag_nxt  = q_sat ? tsev_pkg::MAG_MAX : div_quot[tsev_pkg::MAG_W-1:0];
            flag_nxt = flag_r || q_sat;
            tneg_nxt = tneg_r ^ xneg_r;
          end
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (sel) begin
          if (ovf) begin
            acc_nxt  = acc_r[63] ? tsev_pkg::SUM_MIN : tsev_pkg::SUM_MAX;
            flag_nxt = 1'b1;
          end else begin
            acc_nxt = s;
          end
        end
        if (j_r == jlast_r) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_data_nxt  = acc_r;
          out_flag_nxt  = flag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    xmag_r     <= xmag_nxt;
    xneg_r     <= xneg_nxt;
    j_r        <= j_nxt;
    jlast_r    <= jlast_nxt;
    mag_r      <= mag_nxt;
    tneg_r     <= tneg_nxt;
    acc_r      <= acc_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL))
    else $error("multiplier finished outside the multiply step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_pi_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (op_r == tsev_pkg::OP_PI)) |=> !out_tuser)
    else $error("pi series raised overflow");

  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_STEP) || (state_r == S_ADD)) |-> (j_r <= jlast_r))
    else $error("term index ran past the last term");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("ready held across an accepted transfer");

endmodule
